// ===== sv/urmf_pkg.sv =====
package urmf_pkg;

  localparam int unsigned RxDepthDefault = 64;

  localparam int unsigned OffW  = 12;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;

  localparam int unsigned SDataW = 40;
  localparam int unsigned MDataW = 32;

  typedef enum logic [1:0] {
    OpRead    = 2'd0,
    OpWrite   = 2'd1,
    OpWriteB  = 2'd2,
    OpRxByte  = 2'd3
  } op_e;

  localparam logic [OffW-1:0] OffDr    = 12'h000;
  localparam logic [OffW-1:0] OffFr    = 12'h018;
  localparam logic [OffW-1:0] OffIbrd  = 12'h024;
  localparam logic [OffW-1:0] OffFbrd  = 12'h028;
  localparam logic [OffW-1:0] OffLcrh  = 12'h02C;
  localparam logic [OffW-1:0] OffCr    = 12'h030;
  localparam logic [OffW-1:0] OffIfls  = 12'h034;
  localparam logic [OffW-1:0] OffImsc  = 12'h038;
  localparam logic [OffW-1:0] OffRis   = 12'h03C;
  localparam logic [OffW-1:0] OffMis   = 12'h040;
  localparam logic [OffW-1:0] OffIcr   = 12'h044;
  localparam logic [OffW-1:0] OffPid0  = 12'hFE0;
  localparam logic [OffW-1:0] OffPid1  = 12'hFE4;
  localparam logic [OffW-1:0] OffPid2  = 12'hFE8;
  localparam logic [OffW-1:0] OffPid3  = 12'hFEC;
  localparam logic [OffW-1:0] OffCid0  = 12'hFF0;
  localparam logic [OffW-1:0] OffCid1  = 12'hFF4;
  localparam logic [OffW-1:0] OffCid2  = 12'hFF8;
  localparam logic [OffW-1:0] OffCid3  = 12'hFFC;

  localparam logic [WordW-1:0] Pid0Val = 16'h0011;
  localparam logic [WordW-1:0] Pid1Val = 16'h0010;
  localparam logic [WordW-1:0] Pid2Val = 16'h0014;
  localparam logic [WordW-1:0] Pid3Val = 16'h0000;
  localparam logic [WordW-1:0] Cid0Val = 16'h000D;
  localparam logic [WordW-1:0] Cid1Val = 16'h00F0;
  localparam logic [WordW-1:0] Cid2Val = 16'h0005;
  localparam logic [WordW-1:0] Cid3Val = 16'h00B1;

  localparam logic [WordW-1:0] FrEmpty    = 16'd16;
  localparam logic [WordW-1:0] FrNotEmpty = 16'd64;

  localparam int unsigned RxBit = 4;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [ByteW-1:0] wdata;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic             pop;
    logic [WordW-1:0] read_data;
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic             irq_pulse;
    logic             bad_offset;
  } result_t;

endpackage

// ===== sv/urmf_fifo.sv =====
module urmf_fifo #(
  parameter int unsigned RX_DEPTH = urmf_pkg::RxDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  urmf_pkg::fifo_req_t        req_i,
  output urmf_pkg::fifo_stat_t       stat_o,
  output logic [urmf_pkg::ByteW-1:0] rdata_o
);
  import urmf_pkg::*;

  localparam int unsigned AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RX_DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(RX_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(RX_DEPTH);

  logic [ByteW-1:0] mem [RX_DEPTH];
  logic [AW-1:0]    rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [ByteW-1:0] rdata_q;

  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    cnt_d  = cnt_q;
    if (req_i.push) begin
      wptr_d = (wptr_q == LastAddr) ? '0 : wptr_q + AW'(1);
      cnt_d  = cnt_q + CW'(1);
    end else if (req_i.pop) begin
      rptr_d = (rptr_q == LastAddr) ? '0 : rptr_q + AW'(1);
      cnt_d  = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wptr_q] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rdata_q <= mem[rptr_q];
    end
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign rdata_o      = rdata_q;

endmodule

// ===== sv/urmf_regs.sv =====
module urmf_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 opcode_i,
  input  logic [urmf_pkg::OffW-1:0]  offset_i,
  input  logic [urmf_pkg::WordW-1:0] write_data_i,
  input  logic [urmf_pkg::ByteW-1:0] rx_byte_i,
  input  urmf_pkg::fifo_stat_t       fifo_stat_i,
  output urmf_pkg::fifo_req_t        fifo_req_o,
  output urmf_pkg::result_t          result_o
);
  import urmf_pkg::*;

  logic [WordW-1:0] cr_q, cr_d, imsc_q, imsc_d, ibrd_q, ibrd_d;
  logic [WordW-1:0] fbrd_q, fbrd_d, lcrh_q, lcrh_d;
  logic             pend_q, pend_d;
  logic [WordW-1:0] ris;
  op_e              op;
  result_t          res;
  fifo_req_t        req;

  assign op  = op_e'(opcode_i);
  assign ris = pend_q ? (WordW'(1) << RxBit) : '0;

  always_comb begin
    cr_d   = cr_q;
    imsc_d = imsc_q;
    ibrd_d = ibrd_q;
    fbrd_d = fbrd_q;
    lcrh_d = lcrh_q;
    pend_d = pend_q;
    res    = '0;
    req    = '0;
    req.wdata = rx_byte_i;
    case (op)
      OpRead: begin
        case (offset_i)
          OffDr: begin
            pend_d  = 1'b0;
            req.pop = accept_i && !fifo_stat_i.empty;
            res.pop = !fifo_stat_i.empty;
          end
          OffFr:   res.read_data = fifo_stat_i.empty ? FrEmpty : FrNotEmpty;
          OffCr:   res.read_data = cr_q;
          OffImsc: res.read_data = imsc_q;
          OffRis:  res.read_data = ris;
          OffMis:  res.read_data = ris & imsc_q;
          OffFbrd: res.read_data = fbrd_q;
          OffIbrd: res.read_data = ibrd_q;
          OffLcrh: res.read_data = lcrh_q;
          OffPid0: res.read_data = Pid0Val;
          OffPid1: res.read_data = Pid1Val;
          OffPid2: res.read_data = Pid2Val;
          OffPid3: res.read_data = Pid3Val;
          OffCid0: res.read_data = Cid0Val;
          OffCid1: res.read_data = Cid1Val;
          OffCid2: res.read_data = Cid2Val;
          OffCid3: res.read_data = Cid3Val;
          default: res.bad_offset = 1'b1;
        endcase
      end
      OpWrite: begin
        case (offset_i)
          OffDr: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = write_data_i[ByteW-1:0];
          end
          OffFbrd: fbrd_d = write_data_i;
          OffImsc: begin
            res.irq_pulse = write_data_i[RxBit] && !imsc_q[RxBit] && pend_q;
            imsc_d        = write_data_i;
          end
          OffIbrd: ibrd_d = write_data_i;
          OffLcrh: lcrh_d = write_data_i;
          OffIcr: begin
            if (write_data_i[RxBit]) begin
              pend_d = 1'b0;
            end
          end
          OffCr:   cr_d = write_data_i;
          OffIfls: ;
          default: res.bad_offset = 1'b1;
        endcase
      end
      OpWriteB: begin
        if (offset_i == OffDr) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = write_data_i[ByteW-1:0];
        end else begin
          res.bad_offset = 1'b1;
        end
      end
      OpRxByte: begin
        req.push      = accept_i && !fifo_stat_i.full;
        pend_d        = 1'b1;
        res.irq_pulse = imsc_q[RxBit];
      end
      default: res.bad_offset = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q   <= '0;
      imsc_q <= '0;
      ibrd_q <= '0;
      fbrd_q <= '0;
      lcrh_q <= '0;
      pend_q <= 1'b0;
    end else if (accept_i) begin
      cr_q   <= cr_d;
      imsc_q <= imsc_d;
      ibrd_q <= ibrd_d;
      fbrd_q <= fbrd_d;
      lcrh_q <= lcrh_d;
      pend_q <= pend_d;
    end
  end

  assign fifo_req_o = req;
  assign result_o   = res;

endmodule

// ===== sv/uart_register_model_with_rx_fifo.sv =====
// UART register block with a receive FIFO. Each input transfer is one halfword read,
// halfword write, byte write or arriving receive byte, and yields exactly one result
// transfer, in order. One transfer is taken every cycle unless the stage and output
// register are full and the output stalls; they lie between the sides so input keeps
// flowing while a result waits. The receive FIFO is a RX_DEPTH x 8 memory with one
// write and one registered read port; a data-register read issues the FIFO read in
// the accept cycle and the popped byte joins the result in the next cycle.
module uart_register_model_with_rx_fifo #(
  parameter int unsigned RX_DEPTH = urmf_pkg::RxDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // opcode[1:0], offset[13:2], write_data[29:14], rx_byte[37:30], zero fill
  input  logic [urmf_pkg::SDataW-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // read_data[15:0], tx_valid[16], tx_byte[24:17], irq_pulse[25], bad_offset[26], zero fill
  output logic [urmf_pkg::MDataW-1:0] m_axis_tdata
);
  import urmf_pkg::*;

  logic             accept;
  logic             s1_valid_q, s1_adv;
  result_t          s1_res_q;
  result_t          res;
  fifo_req_t        fifo_req;
  fifo_stat_t       fifo_stat;
  logic [ByteW-1:0] fifo_rdata;
  logic [WordW-1:0] s1_read_data;
  logic             m_valid_q;
  logic [MDataW-1:0] m_data_q, m_data_d;

  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  urmf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (s_axis_tdata[1:0]),
    .offset_i    (s_axis_tdata[13:2]),
    .write_data_i(s_axis_tdata[29:14]),
    .rx_byte_i   (s_axis_tdata[37:30]),
    .fifo_stat_i (fifo_stat),
    .fifo_req_o  (fifo_req),
    .result_o    (res)
  );

  urmf_fifo #(
    .RX_DEPTH(RX_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .stat_o (fifo_stat),
    .rdata_o(fifo_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
  end

  assign s1_read_data = s1_res_q.pop ? {{(WordW-ByteW){1'b0}}, fifo_rdata}
                                     : s1_res_q.read_data;

  assign m_data_d = {{(MDataW-27){1'b0}}, s1_res_q.bad_offset, s1_res_q.irq_pulse,
                     s1_res_q.tx_byte, s1_res_q.tx_valid, s1_read_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (!m_valid_q || m_axis_tready) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_req.pop |-> !fifo_stat.empty)
    else $error("pop issued on empty receive FIFO");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_req.push |-> !fifo_stat.full && !fifo_req.pop)
    else $error("push issued on full FIFO or together with pop");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && m_valid_q && !m_axis_tready)
    else $error("input stalled while a stage is free");

  a_bad_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[26] |-> !m_axis_tdata[16] && m_axis_tdata[15:0] == '0)
    else $error("bad offset result carries data");
`endif

endmodule
